/* hw/rtl/lbfi_pkg.sv */
// Shared constants and types for the line versus box face intersection block.
// Used by lbfi_div and line_box_face_intersect; depends on nothing else.
`default_nettype none

package lbfi_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned NumAxes     = 3;
  localparam int unsigned NumLanes    = 6;
  localparam int unsigned CfgIdxW     = 3;
  // Near-zero threshold on a direction component: 0.01 in Q16.16.
  localparam logic [CoordW-1:0] EpsQ  = 32'd655;

  // Divider geometry: a 64-bit product over a divisor of at least 656, so the
  // quotient stays below 2^55 and 56 quotient bits suffice.
  localparam int unsigned DividendW   = 64;
  localparam int unsigned DivisorW    = 32;
  localparam int unsigned QuotW       = 56;
  localparam int unsigned DivBitsPerStage = 4;
  localparam int unsigned DivStages   = QuotW / DivBitsPerStage;

  // Candidate coordinate before saturation.
  localparam int unsigned CandW       = QuotW + 2;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_e;

  // One divider stage: partial remainder, dividend bits still to bring down,
  // quotient so far, divisor and result sign.
  typedef struct packed {
    logic [DivisorW-1:0] rem;
    logic [QuotW-1:0]    bits;
    logic [QuotW-1:0]    quo;
    logic [DivisorW-1:0] dvs;
    logic                neg;
  } div_stage_t;

endpackage

`default_nettype wire

/* hw/rtl/lbfi_div.sv */
// Pipelined unsigned restoring divider lane, four quotient bits per stage.
// Depends on lbfi_pkg; payload registers only, advanced by the shared enable.
`default_nettype none

module lbfi_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [lbfi_pkg::DividendW-1:0] dividend_i,
  input  logic [lbfi_pkg::DivisorW-1:0]  divisor_i,
  input  logic                          neg_i,
  output logic [lbfi_pkg::QuotW-1:0]     quot_o,
  output logic                          neg_o
);
  import lbfi_pkg::*;

  div_stage_t st_in;
  div_stage_t st_d [DivStages];
  div_stage_t st_q [DivStages];

  // The top bits of the dividend are already below the divisor, so they seed
  // the remainder directly.
  assign st_in.rem  = {{(DivisorW-(DividendW-QuotW)){1'b0}}, dividend_i[DividendW-1:QuotW]};
  assign st_in.bits = dividend_i[QuotW-1:0];
  assign st_in.quo  = '0;
  assign st_in.dvs  = divisor_i;
  assign st_in.neg  = neg_i;

  always_comb begin
    div_stage_t      cur;
    logic [DivisorW:0] trial;
    for (int g = 0; g < DivStages; g++) begin
      cur = (g == 0) ? st_in : st_q[g-1];
      for (int b = 0; b < DivBitsPerStage; b++) begin
        trial    = {cur.rem, cur.bits[QuotW-1]};
        cur.bits = {cur.bits[QuotW-2:0], 1'b0};
        if (trial >= {1'b0, cur.dvs}) begin
          trial   = trial - {1'b0, cur.dvs};
          cur.quo = {cur.quo[QuotW-2:0], 1'b1};
        end else begin
          cur.quo = {cur.quo[QuotW-2:0], 1'b0};
        end
        cur.rem = trial[DivisorW-1:0];
      end
      st_d[g] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < DivStages; g++) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  assign quot_o = st_q[DivStages-1].quo;
  assign neg_o  = st_q[DivStages-1].neg;

endmodule

`default_nettype wire

/* hw/rtl/line_box_face_intersect.sv */
// Line versus axis-aligned box face intersection, fully pipelined top level.
// Depends on lbfi_pkg and lbfi_div (six divider lanes, two per axis).
//
//   Channel   Direction  Handshake                Contents
//   in        input      in_valid_i/in_ready_o    origin_*, heading_*
//   out       output     out_valid_o/out_ready_i  hit, hit_axis, hit_x/y/z
//   cfg       input      cfg_we_i                 box bounds by cfg_index_i
//
// One word enters per cycle while the output is not stalled. Stages: input,
// multiply, 14 divider stages, add-and-compare and the output register.
// The divider lanes (four quotient bits per stage) set the depth.
// Reset clears the valid bits and the box to zero; payload is not reset.
// A stall on the output freezes the whole pipeline, so nothing is lost.
`default_nettype none

module line_box_face_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lbfi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbfi_pkg::CoordW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [lbfi_pkg::CoordW-1:0] origin_x_i,
  input  logic signed [lbfi_pkg::CoordW-1:0] origin_y_i,
  input  logic signed [lbfi_pkg::CoordW-1:0] origin_z_i,
  input  logic signed [lbfi_pkg::CoordW-1:0] heading_x_i,
  input  logic signed [lbfi_pkg::CoordW-1:0] heading_y_i,
  input  logic signed [lbfi_pkg::CoordW-1:0] heading_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [1:0]                    hit_axis_o,
  output logic signed [lbfi_pkg::CoordW-1:0] hit_x_o,
  output logic signed [lbfi_pkg::CoordW-1:0] hit_y_o,
  output logic signed [lbfi_pkg::CoordW-1:0] hit_z_o
);
  import lbfi_pkg::*;

  typedef struct packed {
    logic [NumAxes-1:0][CoordW-1:0] p;
    logic [NumAxes-1:0][CoordW-1:0] face;
    logic [NumAxes-1:0]             tried;
  } ctx_t;

  // Lane 2a+j divides for the j-th coordinate other than axis a.
  function automatic logic [1:0] other_axis(input int a, input int j);
    if (j == 0) begin
      return (a == 0) ? 2'd1 : 2'd0;
    end
    return (a == 2) ? 2'd1 : 2'd2;
  endfunction

  logic en;

  // Configuration registers.
  logic [NumAxes-1:0][CoordW-1:0] box_min_q, box_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_q <= '0;
      box_max_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIN_X: box_min_q[0] <= cfg_data_i;
        REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        REG_MAX_X: box_max_q[0] <= cfg_data_i;
        REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits.
  logic                 v_s1_q, v_s2_q, v_f1_q, out_valid_q;
  logic [DivStages-1:0] v_div_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s1_q      <= 1'b0;
      v_s2_q      <= 1'b0;
      v_div_q     <= '0;
      v_f1_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_s1_q      <= in_valid_i;
      v_s2_q      <= v_s1_q;
      v_div_q     <= {v_div_q[DivStages-2:0], v_s2_q};
      v_f1_q      <= v_div_q[DivStages-1];
      out_valid_q <= v_f1_q;
    end
  end

  // Stage 1: face selection, face distance and magnitudes.
  logic [NumAxes-1:0][CoordW-1:0] p_in, d_in;
  ctx_t                           ctx_s1_d, ctx_s1_q;
  logic [NumAxes-1:0][CoordW-1:0] num_abs_d, num_abs_q, d_abs_d, d_abs_q;
  logic [NumAxes-1:0]             num_neg_d, num_neg_q, d_neg_d, d_neg_q;

  assign p_in = {origin_z_i, origin_y_i, origin_x_i};
  assign d_in = {heading_z_i, heading_y_i, heading_x_i};

  always_comb begin
    logic signed [CoordW:0] num;
    for (int k = 0; k < NumAxes; k++) begin
      d_neg_d[k]        = d_in[k][CoordW-1];
      d_abs_d[k]        = d_neg_d[k] ? (~d_in[k] + 1'b1) : d_in[k];
      ctx_s1_d.tried[k] = d_abs_d[k] > EpsQ;
      ctx_s1_d.face[k]  = d_neg_d[k] ? box_min_q[k] : box_max_q[k];
      ctx_s1_d.p[k]     = p_in[k];
      num = $signed({ctx_s1_d.face[k][CoordW-1], ctx_s1_d.face[k]})
          - $signed({p_in[k][CoordW-1], p_in[k]});
      num_neg_d[k] = num[CoordW];
      num_abs_d[k] = num_neg_d[k] ? CoordW'(-num) : num[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_s1_q  <= ctx_s1_d;
      num_abs_q <= num_abs_d;
      num_neg_q <= num_neg_d;
      d_abs_q   <= d_abs_d;
      d_neg_q   <= d_neg_d;
    end
  end

  // Stage 2: one 32 by 32 magnitude product per lane.
  ctx_t                             ctx_s2_q;
  logic [NumLanes-1:0][DividendW-1:0] prod_q;
  logic [NumLanes-1:0][DivisorW-1:0]  dvs_q;
  logic [NumLanes-1:0]                neg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_s2_q <= ctx_s1_q;
      for (int a = 0; a < NumAxes; a++) begin
        for (int j = 0; j < 2; j++) begin
          prod_q[2*a+j] <= DividendW'(num_abs_q[a]) * DividendW'(d_abs_q[other_axis(a, j)]);
          dvs_q[2*a+j]  <= d_abs_q[a];
          neg_q[2*a+j]  <= num_neg_q[a] ^ d_neg_q[other_axis(a, j)] ^ d_neg_q[a];
        end
      end
    end
  end

  // Divider lanes, with the context carried alongside.
  logic [NumLanes-1:0][QuotW-1:0] quo;
  logic [NumLanes-1:0]            quo_neg;
  ctx_t                           ctx_div_q [DivStages];

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    lbfi_div u_div (
      .clk_i      (clk_i),
      .en_i       (en),
      .dividend_i (prod_q[l]),
      .divisor_i  (dvs_q[l]),
      .neg_i      (neg_q[l]),
      .quot_o     (quo[l]),
      .neg_o      (quo_neg[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_div_q[0] <= ctx_s2_q;
      for (int g = 1; g < DivStages; g++) begin
        ctx_div_q[g] <= ctx_div_q[g-1];
      end
    end
  end

  // Stage F1: signed quotient plus origin, then the inclusive bound tests.
  ctx_t                           ctx_f1_q;
  logic [NumLanes-1:0][CandW-1:0] cand_d, cand_q;
  logic [NumLanes-1:0]            inside_d, inside_q;

  always_comb begin
    logic signed [CandW-1:0] qs, lo, hi, c;
    logic [1:0]              o;
    for (int a = 0; a < NumAxes; a++) begin
      for (int j = 0; j < 2; j++) begin
        o  = other_axis(a, j);
        qs = quo_neg[2*a+j] ? -$signed({2'b00, quo[2*a+j]}) : $signed({2'b00, quo[2*a+j]});
        c  = $signed({{(CandW-CoordW){ctx_div_q[DivStages-1].p[o][CoordW-1]}},
                      ctx_div_q[DivStages-1].p[o]}) + qs;
        lo = $signed({{(CandW-CoordW){box_min_q[o][CoordW-1]}}, box_min_q[o]});
        hi = $signed({{(CandW-CoordW){box_max_q[o][CoordW-1]}}, box_max_q[o]});
        cand_d[2*a+j]   = c;
        inside_d[2*a+j] = (c >= lo) && (c <= hi);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_f1_q <= ctx_div_q[DivStages-1];
      cand_q   <= cand_d;
      inside_q <= inside_d;
    end
  end

  // Stage F2: first accepted axis wins; coordinates saturate to 32 bits.
  function automatic logic [CoordW-1:0] sat32(input logic [CandW-1:0] v);
    if (v[CandW-1:CoordW-1] == '0 || v[CandW-1:CoordW-1] == '1) begin
      return v[CoordW-1:0];
    end
    return v[CandW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
  endfunction

  logic                           hit_d, hit_q;
  logic [1:0]                     axis_d, axis_q;
  logic [NumAxes-1:0][CoordW-1:0] coord_d, coord_q;

  always_comb begin
    hit_d   = 1'b0;
    axis_d  = AXIS_X;
    coord_d = '0;
    priority if (ctx_f1_q.tried[0] && inside_q[0] && inside_q[1]) begin
      hit_d      = 1'b1;
      axis_d     = AXIS_X;
      coord_d[0] = ctx_f1_q.face[0];
      coord_d[1] = sat32(cand_q[0]);
      coord_d[2] = sat32(cand_q[1]);
    end else if (ctx_f1_q.tried[1] && inside_q[2] && inside_q[3]) begin
      hit_d      = 1'b1;
      axis_d     = AXIS_Y;
      coord_d[0] = sat32(cand_q[2]);
      coord_d[1] = ctx_f1_q.face[1];
      coord_d[2] = sat32(cand_q[3]);
    end else if (ctx_f1_q.tried[2] && inside_q[4] && inside_q[5]) begin
      hit_d      = 1'b1;
      axis_d     = AXIS_Z;
      coord_d[0] = sat32(cand_q[4]);
      coord_d[1] = sat32(cand_q[5]);
      coord_d[2] = ctx_f1_q.face[2];
    end else begin
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit_d;
      axis_q  <= axis_d;
      coord_q <= coord_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign hit_axis_o  = axis_q;
  assign hit_x_o     = coord_q[0];
  assign hit_y_o     = coord_q[1];
  assign hit_z_o     = coord_q[2];

  // A stall must hold the stage 1, divider and F1 valid bits in place.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_div_q) && $stable(v_f1_q) && $stable(v_s1_q))
    else $error("pipeline valid bits moved during a stall");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_axis_o == AXIS_X && hit_x_o == '0
                              && hit_y_o == '0 && hit_z_o == '0)
    else $error("miss word carries a nonzero axis or point");

  a_axis_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hit_axis_o == AXIS_X || hit_axis_o == AXIS_Y || hit_axis_o == AXIS_Z)
    else $error("hit axis out of range");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the output word is stalled");

endmodule

`default_nettype wire

/* tb/line_box_face_intersect_tb.sv */
// Self-checking testbench for line_box_face_intersect: random and directed lines
// against several box settings, with a predictor of the face hit. Depends on lbfi_pkg.
`default_nettype none

module line_box_face_intersect_tb;
  import lbfi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] hdg [3];
  } line_t;

  typedef struct {
    logic        hit;
    logic [1:0]  axis;
    logic [31:0] pos [3];
  } face_hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] heading_x_i = '0, heading_y_i = '0, heading_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic [1:0] hit_axis_o;
  logic signed [31:0] hit_x_o, hit_y_o, hit_z_o;

  line_box_face_intersect uut (.*);

  always #6 clk_i = ~clk_i;

  line_t     pending_lines [$];
  face_hit_t expected_hits [$];
  longint    box_lo [3];
  longint    box_hi [3];
  int errors = 0;
  int lines_sent = 0;
  int hits_seen = 0;
  int results_seen = 0;
  int hold_off = 0;
  bit long_stall_req = 1'b0;

  function automatic logic [31:0] saturate32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic face_hit_t predict_face_hit(line_t ln);
    face_hit_t r;
    longint p [3], d [3], c [3];
    longint mag, face, num;
    bit ok;
    r.hit = 1'b0;
    r.axis = AXIS_X;
    for (int k = 0; k < 3; k++) begin
      r.pos[k] = '0;
      p[k] = ln.org[k];
      d[k] = ln.hdg[k];
    end
    for (int a = 0; a < 3; a++) begin
      mag = d[a] < 0 ? -d[a] : d[a];
      if (mag <= longint'(EpsQ)) continue;
      face = d[a] > 0 ? box_hi[a] : box_lo[a];
      num = face - p[a];
      ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (k == a) c[k] = face;
        else begin
          // SystemVerilog division truncates toward zero, as required.
          c[k] = p[k] + (num * d[k]) / d[a];
          if (c[k] < box_lo[k] || c[k] > box_hi[k]) ok = 1'b0;
        end
      end
      if (ok) begin
        r.hit = 1'b1;
        r.axis = axis_e'(a);
        for (int k = 0; k < 3; k++) r.pos[k] = saturate32(c[k]);
        return r;
      end
    end
    return r;
  endfunction

  // Records whether the word on offer was taken at the last rising edge.
  bit in_taken = 1'b0;
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
  end

  // Driver: bursts of words with random gaps, payload held until accepted.
  int gap_left = 0;
  int burst_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // keep offering the same word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_lines.size() > 0) begin
        line_t ln;
        ln = pending_lines.pop_front();
        origin_x_i <= ln.org[0];
        origin_y_i <= ln.org[1];
        origin_z_i <= ln.org[2];
        heading_x_i <= ln.hdg[0];
        heading_y_i <= ln.hdg[1];
        heading_z_i <= ln.hdg[2];
        in_valid_i <= 1'b1;
        expected_hits.push_back(predict_face_hit(ln));
        lines_sent++;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(30, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end
      end else in_valid_i <= 1'b0;
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  int stall_phase = 0;
  always @(negedge clk_i) begin
    if (long_stall_req && hold_off == 0) begin
      hold_off <= 60;
      long_stall_req <= 1'b0;
      out_ready_i <= 1'b0;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
    end else begin
      hold_off <= 0;
      stall_phase <= (stall_phase + 1) % 64;
      out_ready_i <= (stall_phase < 20) ? 1'b1 : ($urandom_range(3, 0) != 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      face_hit_t e;
      results_seen++;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0d", $time, hit_o);
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (e.hit) hits_seen++;
        if (hit_o !== e.hit || hit_axis_o !== e.axis || hit_x_o !== e.pos[0] ||
            hit_y_o !== e.pos[1] || hit_z_o !== e.pos[2]) begin
          $display("%0t: mismatch expected hit=%0d axis=%0d pos=%h %h %h", $time,
                   e.hit, e.axis, e.pos[0], e.pos[1], e.pos[2]);
          $display("%0t:          actual   hit=%0d axis=%0d pos=%h %h %h", $time,
                   hit_o, hit_axis_o, hit_x_o, hit_y_o, hit_z_o);
          errors++;
        end
      end
    end
  end

  task automatic write_box(cfg_reg_e idx, logic signed [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx <= REG_MIN_Z) box_lo[idx] = val;
    else box_hi[idx - REG_MAX_X] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_box(logic signed [31:0] lo [3], logic signed [31:0] hi [3]);
    write_box(REG_MIN_X, lo[0]);
    write_box(REG_MIN_Y, lo[1]);
    write_box(REG_MIN_Z, lo[2]);
    write_box(REG_MAX_X, hi[0]);
    write_box(REG_MAX_Y, hi[1]);
    write_box(REG_MAX_Z, hi[2]);
  endtask

  task automatic drain;
    while (pending_lines.size() > 0 || in_valid_i || expected_hits.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(int span);
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(2 * span, 0)) - span;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_heading();
    case ($urandom_range(11, 0))
      0: return 0;
      1: return $signed($urandom_range(1310, 0)) - 655;
      2: return ($urandom_range(1, 0)) ? 32'sd656 : -32'sd656;
      3: return $urandom();
      4: return ($urandom_range(1, 0)) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(20 << 16, 0)) - (10 << 16);
    endcase
  endfunction

  task automatic queue_line(logic signed [31:0] o0, o1, o2, h0, h1, h2);
    line_t ln;
    ln.org[0] = o0; ln.org[1] = o1; ln.org[2] = o2;
    ln.hdg[0] = h0; ln.hdg[1] = h1; ln.hdg[2] = h2;
    pending_lines.push_back(ln);
  endtask

  task automatic queue_random_lines(int n, int span);
    for (int i = 0; i < n; i++)
      queue_line(rand_coord(span), rand_coord(span), rand_coord(span),
                 rand_heading(), rand_heading(), rand_heading());
  endtask

  initial begin
    logic signed [31:0] lo [3], hi [3];
    int one;
    one = 1 << 16;
    for (int k = 0; k < 3; k++) begin
      box_lo[k] = 0;
      box_hi[k] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unit box around the origin for the directed words.
    lo = '{-one, -one, -one};
    hi = '{one, one, one};
    set_box(lo, hi);
    queue_line(0, 0, 0, 0, 0, 0);                    // all headings zero
    queue_line(0, 0, 0, 655, -655, 655);             // all below threshold
    queue_line(0, 0, 0, 656, 0, 0);                  // just above threshold
    queue_line(0, 0, 0, -656, 0, 0);
    queue_line(0, 0, 0, 0, one, 0);
    queue_line(0, 0, 0, 0, 0, -one);
    queue_line(3 * one, 0, 0, one, 0, 0);            // hit behind the point
    queue_line(0, 0, 0, one, one, one);              // corner tie, x wins
    queue_line(0, 0, 0, one, 2 * one, 0);            // x misses, y hits
    queue_line(5 * one, 5 * one, 0, one, 0, 0);      // miss
    queue_line(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
               32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    queue_line(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               32'sh80000000, 32'sh7fffffff, 1);
    queue_line(0, 0, 0, 32'sh80000000, 32'sh7fffffff, 656);
    queue_line(-1, -1, -1, -1, -1, -1);
    drain();

    // Extreme box: saturation on the output.
    lo = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    hi = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    set_box(lo, hi);
    queue_line(0, 0, 0, 656, 32'sh7fffffff, 0);
    queue_line(0, 0, 0, -656, 32'sh80000000, 32'sh7fffffff);
    queue_random_lines(150, 100 * one);
    drain();

    // Inverted box on y.
    lo = '{-one, 2 * one, -one};
    hi = '{one, -2 * one, one};
    set_box(lo, hi);
    queue_random_lines(100, 4 * one);
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    lo = '{-4 * one, -4 * one, -4 * one};
    hi = '{4 * one, 4 * one, 4 * one};
    set_box(lo, hi);
    queue_random_lines(200, 8 * one);
    long_stall_req = 1'b1;
    drain();

    // Random boxes with random lines.
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 3; k++) begin
        lo[k] = rand_coord(20 * one);
        hi[k] = ($urandom_range(7, 0) == 0) ? rand_coord(20 * one)
                                            : lo[k] + $urandom_range(10 * one, 0);
        if (hi[k] < lo[k] && $urandom_range(1, 0)) hi[k] = 32'sh7fffffff;
      end
      set_box(lo, hi);
      queue_random_lines(150, 30 * one);
      drain();
    end

    $display("Covered %0d lines over eight box settings, %0d of them hits,",
             lines_sent, hits_seen);
    $display("including near-zero headings, saturation and a long output stall.");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule

`default_nettype wire
